### rtl/core/yuvlc_pkg.sv
`timescale 1ns / 1ps

package yuvlc_pkg;

  localparam int OFF_W  = 25;
  localparam int DIM_W  = 13;
  localparam int BYTE_W = 8;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [2:0] REG_SRC_FMT = 3'd0;
  localparam logic [2:0] REG_TGT_FMT = 3'd1;
  localparam logic [2:0] REG_FRAME_W = 3'd2;
  localparam logic [2:0] REG_FRAME_H = 3'd3;
  localparam logic [2:0] REG_COPY_W  = 3'd4;
  localparam logic [2:0] REG_COPY_R  = 3'd5;

  localparam logic             RST_SRC_FMT = 1'b0;
  localparam logic [1:0]       RST_TGT_FMT = 2'd0;
  localparam logic [DIM_W-1:0] RST_FRAME_W = 13'd352;
  localparam logic [DIM_W-1:0] RST_FRAME_H = 13'd288;
  localparam logic [DIM_W-1:0] RST_COPY_W  = 13'd352;
  localparam logic [DIM_W-1:0] RST_COPY_R  = 13'd288;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] b;
  } item_t;

  typedef struct packed {
    logic [OFF_W-1:0]  offset;
    logic [BYTE_W-1:0] value;
    logic              last;
    logic              done;
  } wr_t;

  typedef struct packed {
    logic             tgt_i420;
    logic             tgt_swap;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] cw;
    logic [DIM_W-1:0] cr;
    logic [OFF_W-1:0] wh;
    logic [OFF_W-1:0] qtr;
  } cfg_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                               input logic [DIM_W:0] cap);
    logic [DIM_W:0] t;
    t = {1'b0, v[DIM_W-1:1], 1'b0};
    if (t < (DIM_W+1)'(2)) t = (DIM_W+1)'(2);
    if (t > cap) t = {cap[DIM_W:1], 1'b0};
    if (t < (DIM_W+1)'(2)) t = (DIM_W+1)'(2);
    return t[DIM_W-1:0];
  endfunction

endpackage

### rtl/core/yuvlc_fifo.sv
`timescale 1ns / 1ps

module yuvlc_fifo #(
  parameter int W     = 17,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         full,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + CW'(1);
    end else if (!wr_en && rd_en) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("fifo count out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !full)
    else $error("fifo written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !empty)
    else $error("fifo read while empty");

endmodule

### rtl/core/yuvlc_cfg.sv
`timescale 1ns / 1ps

module yuvlc_cfg #(
  parameter int MAX_DIM = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [yuvlc_pkg::ADDR_W-1:0] paddr,
  input  logic [yuvlc_pkg::DATA_W-1:0] pwdata,
  output logic [yuvlc_pkg::DATA_W-1:0] prdata,
  output logic                         pready,
  output logic                         src_i420,
  output yuvlc_pkg::cfg_t              cfg
);

  localparam int DW = yuvlc_pkg::DIM_W;
  localparam int OW = yuvlc_pkg::OFF_W;
  localparam logic [DW:0] CAP = (DW+1)'(MAX_DIM);

  logic          src_r;
  logic [1:0]    tgt_r;
  logic [DW-1:0] fw_r;
  logic [DW-1:0] fh_r;
  logic [DW-1:0] cwid_r;
  logic [DW-1:0] crow_r;
  logic [OW-1:0] wh_r;
  logic [OW-1:0] qtr_r;

  logic [2:0]      idx;
  logic            wr_en;
  logic [DW-1:0]   w_eff, h_eff;
  logic [2*DW-1:0] prod;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r  <= yuvlc_pkg::RST_SRC_FMT;
      tgt_r  <= yuvlc_pkg::RST_TGT_FMT;
      fw_r   <= yuvlc_pkg::RST_FRAME_W;
      fh_r   <= yuvlc_pkg::RST_FRAME_H;
      cwid_r <= yuvlc_pkg::RST_COPY_W;
      crow_r <= yuvlc_pkg::RST_COPY_R;
    end else if (wr_en) begin
      case (idx)
        yuvlc_pkg::REG_SRC_FMT: src_r  <= pwdata[0];
        yuvlc_pkg::REG_TGT_FMT: tgt_r  <= pwdata[1:0];
        yuvlc_pkg::REG_FRAME_W: fw_r   <= pwdata[DW-1:0];
        yuvlc_pkg::REG_FRAME_H: fh_r   <= pwdata[DW-1:0];
        yuvlc_pkg::REG_COPY_W:  cwid_r <= pwdata[DW-1:0];
        yuvlc_pkg::REG_COPY_R:  crow_r <= pwdata[DW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      yuvlc_pkg::REG_SRC_FMT: prdata = 32'(src_r);
      yuvlc_pkg::REG_TGT_FMT: prdata = 32'(tgt_r);
      yuvlc_pkg::REG_FRAME_W: prdata = 32'(fw_r);
      yuvlc_pkg::REG_FRAME_H: prdata = 32'(fh_r);
      yuvlc_pkg::REG_COPY_W:  prdata = 32'(cwid_r);
      yuvlc_pkg::REG_COPY_R:  prdata = 32'(crow_r);
      default:                prdata = '0;
    endcase
  end

  assign w_eff = yuvlc_pkg::eff_dim(fw_r, CAP);
  assign h_eff = yuvlc_pkg::eff_dim(fh_r, CAP);
  assign prod  = (2*DW)'(w_eff) * (2*DW)'(h_eff);

  always_ff @(posedge clk) begin
    wh_r  <= prod[OW-1:0];
    qtr_r <= OW'(prod[2*DW-1:2]);
  end

  assign src_i420     = src_r;
  assign cfg.tgt_i420 = tgt_r[1];
  assign cfg.tgt_swap = tgt_r[0];
  assign cfg.w        = w_eff;
  assign cfg.cw       = yuvlc_pkg::eff_dim(cwid_r, {1'b0, w_eff});
  assign cfg.cr       = yuvlc_pkg::eff_dim(crow_r, {1'b0, h_eff});
  assign cfg.wh       = wh_r;
  assign cfg.qtr      = qtr_r;

endmodule

### rtl/core/yuvlc_front.sv
`timescale 1ns / 1ps

module yuvlc_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic                         in_is_chroma,
  input  logic [yuvlc_pkg::BYTE_W-1:0] in_first_byte,
  input  logic [yuvlc_pkg::BYTE_W-1:0] in_second_byte,
  input  logic                         src_i420,
  input  logic                         q_pop,
  output logic                         q_vld,
  output yuvlc_pkg::item_t             q_data
);

  yuvlc_pkg::item_t item;
  logic             q_empty;
  logic             q_wr;

  // normalize chroma to (u, v) order
  always_comb begin
    item.kind = in_is_chroma;
    if (in_is_chroma && !src_i420) begin
      item.a = in_second_byte;
      item.b = in_first_byte;
    end else begin
      item.a = in_first_byte;
      item.b = in_second_byte;
    end
  end

  assign q_wr  = push && !full;
  assign q_vld = !q_empty;

  yuvlc_fifo #(
    .W     ($bits(yuvlc_pkg::item_t)),
    .DEPTH (4)
  ) u_item_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_data (item),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .full    (full),
    .empty   (q_empty)
  );

endmodule

### rtl/core/yuvlc_back.sv
`timescale 1ns / 1ps

module yuvlc_back (
  input  logic             clk,
  input  logic             rst_n,
  input  yuvlc_pkg::cfg_t  cfg,
  input  logic             q_vld,
  input  yuvlc_pkg::item_t q_data,
  output logic             q_pop,
  output logic             o_push,
  output yuvlc_pkg::wr_t   o_data,
  input  logic             o_full
);

  localparam int DW = yuvlc_pkg::DIM_W;
  localparam int OW = yuvlc_pkg::OFF_W;
  localparam int BW = yuvlc_pkg::BYTE_W;

  logic [DW-1:0] col_r, col_nxt;
  logic [DW-1:0] row_r, row_nxt;
  logic [OW-1:0] luma_base_r, luma_base_nxt;
  logic [OW-1:0] chroma_base_r, chroma_base_nxt;
  logic          phase_r, phase_nxt;

  logic          hold_vld_r, hold_vld_nxt;
  logic [OW-1:0] hold_base_r, hold_base_nxt;
  logic [OW-1:0] hold_inc_r, hold_inc_nxt;
  logic [BW-1:0] hold_val_r, hold_val_nxt;
  logic          hold_done_r, hold_done_nxt;

  logic          take;
  logic          row_end;
  logic          frame_end;
  logic [DW:0]   col_sum;
  logic [DW:0]   row_sum;
  logic [OW-1:0] off0;

  always_comb begin
    col_nxt         = col_r;
    row_nxt         = row_r;
    luma_base_nxt   = luma_base_r;
    chroma_base_nxt = chroma_base_r;
    phase_nxt       = phase_r;
    hold_vld_nxt    = hold_vld_r;
    hold_base_nxt   = hold_base_r;
    hold_inc_nxt    = hold_inc_r;
    hold_val_nxt    = hold_val_r;
    hold_done_nxt   = hold_done_r;
    take            = 1'b0;
    frame_end       = 1'b0;
    q_pop           = 1'b0;
    o_push          = 1'b0;
    o_data          = '0;
    off0            = '0;

    col_sum = {1'b0, col_r} + (DW+1)'(2);
    row_sum = {1'b0, row_r} + (DW+1)'(1);
    row_end = (col_sum >= {1'b0, cfg.cw});

    if (hold_vld_r) begin
      if (!o_full) begin
        o_push        = 1'b1;
        o_data.offset = hold_base_r + hold_inc_r;
        o_data.value  = hold_val_r;
        o_data.last   = 1'b1;
        o_data.done   = hold_done_r;
        hold_vld_nxt  = 1'b0;
      end
    end else if (q_vld) begin
      if (q_data.kind != phase_r) begin
        // drop an item of the wrong kind
        q_pop = 1'b1;
      end else if (!o_full) begin
        q_pop        = 1'b1;
        take         = 1'b1;
        o_push       = 1'b1;
        hold_vld_nxt = 1'b1;
        col_nxt      = row_end ? '0 : col_sum[DW-1:0];
        if (!phase_r) begin
          off0          = luma_base_r + OW'(col_r);
          o_data.offset = off0;
          o_data.value  = q_data.a;
          hold_base_nxt = off0;
          hold_inc_nxt  = OW'(1);
          hold_val_nxt  = q_data.b;
          hold_done_nxt = 1'b0;
          if (row_end) begin
            row_nxt       = row_sum[DW-1:0];
            luma_base_nxt = luma_base_r + OW'(cfg.w);
            if (row_sum >= {1'b0, cfg.cr}) begin
              row_nxt         = '0;
              phase_nxt       = 1'b1;
              chroma_base_nxt = cfg.wh;
            end
          end
        end else begin
          if (cfg.tgt_i420) begin
            off0          = chroma_base_r + OW'(col_r[DW-1:1]);
            o_data.value  = q_data.a;
            hold_val_nxt  = q_data.b;
            hold_inc_nxt  = cfg.qtr;
          end else begin
            off0          = chroma_base_r + OW'(col_r);
            o_data.value  = cfg.tgt_swap ? q_data.b : q_data.a;
            hold_val_nxt  = cfg.tgt_swap ? q_data.a : q_data.b;
            hold_inc_nxt  = OW'(1);
          end
          o_data.offset = off0;
          hold_base_nxt = off0;
          hold_done_nxt = 1'b0;
          if (row_end) begin
            row_nxt         = row_sum[DW-1:0];
            chroma_base_nxt = chroma_base_r +
                              (cfg.tgt_i420 ? OW'(cfg.w[DW-1:1]) : OW'(cfg.w));
            if (row_sum >= {2'b0, cfg.cr[DW-1:1]}) begin
              frame_end       = 1'b1;
              hold_done_nxt   = 1'b1;
              col_nxt         = '0;
              row_nxt         = '0;
              luma_base_nxt   = '0;
              chroma_base_nxt = '0;
              phase_nxt       = 1'b0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r         <= '0;
      row_r         <= '0;
      luma_base_r   <= '0;
      chroma_base_r <= '0;
      phase_r       <= 1'b0;
      hold_vld_r    <= 1'b0;
    end else begin
      col_r         <= col_nxt;
      row_r         <= row_nxt;
      luma_base_r   <= luma_base_nxt;
      chroma_base_r <= chroma_base_nxt;
      phase_r       <= phase_nxt;
      hold_vld_r    <= hold_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_base_r <= hold_base_nxt;
    hold_inc_r  <= hold_inc_nxt;
    hold_val_r  <= hold_val_nxt;
    hold_done_r <= hold_done_nxt;
  end

  a_hold_blocks_pop: assert property (@(posedge clk) disable iff (!rst_n)
    hold_vld_r |-> !q_pop)
    else $error("queue popped while second write pending");
  a_take_sets_hold: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> hold_vld_r)
    else $error("second write not held after item");
  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    frame_end |=> (!phase_r && row_r == '0 && col_r == '0 && hold_done_r))
    else $error("state not cleared at frame end");
  a_col_even: assert property (@(posedge clk) disable iff (!rst_n)
    !col_r[0])
    else $error("column counter odd");

endmodule

### rtl/core/yuv420_layout_converter_core.sv
`timescale 1ns / 1ps

// Converts a cropped 4:2:0 frame (NV21 or I420 source) into NV12, NV21 or
// I420 byte writes for an output frame buffer.
// Input queue: push/full; an item is two luma bytes or one chroma pair, all
// luma rows first, then the chroma rows. Items of the wrong kind are dropped.
// Result queue: empty/pop; each item gives two writes (offset, byte), the
// second flagged last_of_item, the frame's final write flagged frame_done.
// Configuration: APB-style registers at byte address 4*i, written while idle.
// An item passes through the input queue and the address generator into the
// result queue; its second write waits in a hold register. An item's two
// writes leave one at a time by the one-byte result port; the next item is
// taken only once the second is queued, and a dropped item gives none. Up to
// 4 items queue ahead of the address generator and up to 4 writes wait at the
// output, so a stalled receiver fills them and raises full; nothing is lost.
// Reset: registers take their defaults, counters clear, both queues empty.
module yuv420_layout_converter_core #(
  parameter int MAX_DIM = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic                         in_is_chroma,
  input  logic [yuvlc_pkg::BYTE_W-1:0] in_first_byte,
  input  logic [yuvlc_pkg::BYTE_W-1:0] in_second_byte,
  output logic                         empty,
  input  logic                         pop,
  output logic [yuvlc_pkg::OFF_W-1:0]  out_byte_offset,
  output logic [yuvlc_pkg::BYTE_W-1:0] out_byte_value,
  output logic                         out_last_of_item,
  output logic                         out_frame_done,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [yuvlc_pkg::ADDR_W-1:0] paddr,
  input  logic [yuvlc_pkg::DATA_W-1:0] pwdata,
  output logic [yuvlc_pkg::DATA_W-1:0] prdata,
  output logic                         pready
);

  yuvlc_pkg::cfg_t  cfg;
  yuvlc_pkg::item_t q_data;
  yuvlc_pkg::wr_t   o_data;
  yuvlc_pkg::wr_t   head;
  logic             src_i420;
  logic             q_vld;
  logic             q_pop;
  logic             o_push;
  logic             o_full;

  yuvlc_cfg #(
    .MAX_DIM (MAX_DIM)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .src_i420 (src_i420),
    .cfg      (cfg)
  );

  yuvlc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_is_chroma   (in_is_chroma),
    .in_first_byte  (in_first_byte),
    .in_second_byte (in_second_byte),
    .src_i420       (src_i420),
    .q_pop          (q_pop),
    .q_vld          (q_vld),
    .q_data         (q_data)
  );

  yuvlc_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .q_vld  (q_vld),
    .q_data (q_data),
    .q_pop  (q_pop),
    .o_push (o_push),
    .o_data (o_data),
    .o_full (o_full)
  );

  yuvlc_fifo #(
    .W     ($bits(yuvlc_pkg::wr_t)),
    .DEPTH (4)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (o_push),
    .wr_data (o_data),
    .rd_en   (pop && !empty),
    .rd_data (head),
    .full    (o_full),
    .empty   (empty)
  );

  assign out_byte_offset  = head.offset;
  assign out_byte_value   = head.value;
  assign out_last_of_item = head.last;
  assign out_frame_done   = head.done;

endmodule

### tb/tb_yuv420_layout_converter_core.sv
`timescale 1ns / 1ps

module tb_yuv420_layout_converter_core;

  localparam int MAX_DIM       = 4096;
  localparam int RANDOM_ITEMS  = 350;
  localparam int DRAIN_CYCLES  = 20;
  localparam int QUIET_LIMIT   = 2000;
  localparam int REPORT_LINES  = 40;

  localparam logic       KIND_LUMA   = 1'b0;
  localparam logic       KIND_CHROMA = 1'b1;
  localparam logic       SRC_NV21    = 1'b0;
  localparam logic       SRC_I420    = 1'b1;
  localparam logic [1:0] TGT_NV21    = 2'd1;
  localparam logic [1:0] TGT_I420    = 2'd2;
  localparam logic [1:0] TGT_CODE3   = 2'd3;
  localparam logic [2:0] REG_BAD     = 3'd7;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t   what;
    logic [2:0]  idx;
    logic [31:0] val;
    logic        kind;
    logic [7:0]  a;
    logic [7:0]  b;
    logic        typed;
    logic [1:0]  n;
    logic [24:0] off0;
    logic [7:0]  v0;
    logic [24:0] off1;
    logic [7:0]  v1;
    logic        done;
  } stim_row_t;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                push = 1'b0;
  logic                                full;
  logic                                in_is_chroma = 1'b0;
  logic [yuvlc_pkg::BYTE_W-1:0]        in_first_byte = '0;
  logic [yuvlc_pkg::BYTE_W-1:0]        in_second_byte = '0;
  logic                                empty;
  logic                                pop = 1'b0;
  logic [yuvlc_pkg::OFF_W-1:0]         out_byte_offset;
  logic [yuvlc_pkg::BYTE_W-1:0]        out_byte_value;
  logic                                out_last_of_item;
  logic                                out_frame_done;
  logic                                psel = 1'b0;
  logic                                penable = 1'b0;
  logic                                pwrite = 1'b0;
  logic [yuvlc_pkg::ADDR_W-1:0]        paddr = '0;
  logic [yuvlc_pkg::DATA_W-1:0]        pwdata = '0;
  logic [yuvlc_pkg::DATA_W-1:0]        prdata;
  logic                                pready;

  logic        src_fmt_r;
  logic [1:0]  tgt_fmt_r;
  logic [12:0] frame_w_r, frame_h_r, copy_w_r, copy_r_r;
  logic [12:0] col_cnt, row_cnt;
  logic [24:0] luma_base, chroma_base;
  logic        chroma_phase;

  yuvlc_pkg::wr_t pending_writes[$];
  yuvlc_pkg::wr_t head_write;
  stim_row_t      dir_rows[$];

  int err_count = 0;
  int items_taken = 0;
  int items_dropped = 0;
  int writes_checked = 0;
  int frames_done = 0;
  int random_items = 0;
  int cfg_settings = 0;
  int reg_reads = 0;
  int burst_left = 0;
  int quiet_cycles = 0;
  int stall_mode = 0;
  int mode_left = 0;
  int cycle_cnt = 0;

  yuv420_layout_converter_core #(
    .MAX_DIM(MAX_DIM)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_is_chroma     (in_is_chroma),
    .in_first_byte    (in_first_byte),
    .in_second_byte   (in_second_byte),
    .empty            (empty),
    .pop              (pop),
    .out_byte_offset  (out_byte_offset),
    .out_byte_value   (out_byte_value),
    .out_last_of_item (out_last_of_item),
    .out_frame_done   (out_frame_done),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    if (err_count <= REPORT_LINES) begin
      $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
  endtask

  function automatic logic [12:0] clamp_dim(input logic [12:0] raw, input int cap);
    int d;
    d = raw;
    d = d & ~1;
    if (d < 2) d = 2;
    if (d > cap) d = cap & ~1;
    if (d < 2) d = 2;
    return 13'(d);
  endfunction

  function automatic void clear_frame();
    col_cnt = '0;
    row_cnt = '0;
    luma_base = '0;
    chroma_base = '0;
    chroma_phase = KIND_LUMA;
  endfunction

  // compute the writes one accepted item causes and advance the frame counters
  function automatic logic [1:0] place_bytes(input logic kind, input logic [7:0] b0,
                                             input logic [7:0] b1,
                                             output yuvlc_pkg::wr_t wa,
                                             output yuvlc_pkg::wr_t wb);
    int          w, h, cwe, cre, stride;
    logic [7:0]  u_byte, v_byte, first_out, second_out;
    logic [24:0] off0, off1;
    logic        fin;
    w = clamp_dim(frame_w_r, MAX_DIM);
    h = clamp_dim(frame_h_r, MAX_DIM);
    cwe = clamp_dim(copy_w_r, w);
    cre = clamp_dim(copy_r_r, h);
    wa = '0;
    wb = '0;
    if (kind != chroma_phase) return 2'd0;
    if (chroma_phase == KIND_LUMA) begin
      off0 = luma_base + 25'(col_cnt);
      wa = '{off0, b0, 1'b0, 1'b0};
      wb = '{off0 + 25'd1, b1, 1'b1, 1'b0};
      col_cnt = col_cnt + 13'd2;
      if (col_cnt >= cwe) begin
        col_cnt = '0;
        row_cnt = row_cnt + 13'd1;
        luma_base = luma_base + 25'(w);
        if (row_cnt >= cre) begin
          row_cnt = '0;
          chroma_phase = KIND_CHROMA;
          chroma_base = 25'(w * h);
        end
      end
      return 2'd2;
    end
    u_byte = (src_fmt_r == SRC_I420) ? b0 : b1;
    v_byte = (src_fmt_r == SRC_I420) ? b1 : b0;
    fin = 1'b0;
    if (tgt_fmt_r == TGT_I420 || tgt_fmt_r == TGT_CODE3) begin
      stride = w / 2;
      off0 = chroma_base + 25'(col_cnt / 2);
      off1 = off0 + 25'((w / 2) * (h / 2));
      first_out = u_byte;
      second_out = v_byte;
    end else begin
      stride = w;
      off0 = chroma_base + 25'(col_cnt);
      off1 = off0 + 25'd1;
      first_out = (tgt_fmt_r == TGT_NV21) ? v_byte : u_byte;
      second_out = (tgt_fmt_r == TGT_NV21) ? u_byte : v_byte;
    end
    col_cnt = col_cnt + 13'd2;
    if (col_cnt >= cwe) begin
      col_cnt = '0;
      row_cnt = row_cnt + 13'd1;
      chroma_base = chroma_base + 25'(stride);
      if (row_cnt >= cre / 2) fin = 1'b1;
    end
    wa = '{off0, first_out, 1'b0, 1'b0};
    wb = '{off1, second_out, 1'b1, fin};
    if (fin) begin
      clear_frame();
      frames_done++;
    end
    return 2'd2;
  endfunction

  function automatic void queue_writes(input logic [1:0] n, input yuvlc_pkg::wr_t wa,
                                       input yuvlc_pkg::wr_t wb);
    if (n == 2'd2) begin
      pending_writes.push_back(wa);
      pending_writes.push_back(wb);
    end
  endfunction

  function automatic stim_row_t reg_row(input logic [2:0] idx, input logic [31:0] val);
    stim_row_t r;
    r = '0;
    r.what = ROW_REG;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  function automatic stim_row_t item_row(input logic kind, input logic [7:0] a,
                                         input logic [7:0] b);
    stim_row_t r;
    r = '0;
    r.what = ROW_ITEM;
    r.kind = kind;
    r.a = a;
    r.b = b;
    return r;
  endfunction

  function automatic stim_row_t typed_row(input logic kind, input logic [7:0] a,
                                          input logic [7:0] b, input logic [1:0] n,
                                          input logic [24:0] off0, input logic [7:0] v0,
                                          input logic [24:0] off1, input logic [7:0] v1,
                                          input logic done);
    stim_row_t r;
    r = item_row(kind, a, b);
    r.typed = 1'b1;
    r.n = n;
    r.off0 = off0;
    r.v0 = v0;
    r.off1 = off1;
    r.v1 = v1;
    r.done = done;
    return r;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [12:0] pick_frame_dim();
    case ($urandom_range(0, 9))
      0: return 13'($urandom_range(0, 3));
      1: return 13'($urandom_range(4097, 8191));
      2: return 13'd4096;
      default: return 13'($urandom_range(2, 48));
    endcase
  endfunction

  function automatic logic [12:0] pick_copy_dim(input logic [12:0] frame_raw);
    case ($urandom_range(0, 7))
      0: return (frame_raw <= 13'd48) ? 13'd8191 : 13'd24;
      1: return 13'($urandom_range(0, 3));
      default: return 13'($urandom_range(2, 24));
    endcase
  endfunction

  // hold the item on the port until a transaction takes it
  task automatic send_item(input logic kind, input logic [7:0] a, input logic [7:0] b,
                           output logic [1:0] n, output yuvlc_pkg::wr_t wa,
                           output yuvlc_pkg::wr_t wb);
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
    end
    push <= 1'b1;
    in_is_chroma <= kind;
    in_first_byte <= a;
    in_second_byte <= b;
    do @(posedge clk); while (full);
    burst_left--;
    items_taken++;
    n = place_bytes(kind, a, b, wa, wb);
    if (n == 2'd0) items_dropped++;
  endtask

  task automatic send_random_item();
    logic           kind;
    logic [1:0]     n;
    yuvlc_pkg::wr_t wa, wb;
    kind = ($urandom_range(0, 11) == 0) ? !chroma_phase : chroma_phase;
    send_item(kind, pick_byte(), pick_byte(), n, wa, wb);
    queue_writes(n, wa, wb);
    if (n != 2'd0) random_items++;
  endtask

  // drop push, drain every expected write, then let dropped items clear the queues
  task automatic wait_idle();
    push <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      yuvlc_pkg::REG_SRC_FMT: src_fmt_r = val[0];
      yuvlc_pkg::REG_TGT_FMT: tgt_fmt_r = val[1:0];
      yuvlc_pkg::REG_FRAME_W: frame_w_r = val[12:0];
      yuvlc_pkg::REG_FRAME_H: frame_h_r = val[12:0];
      yuvlc_pkg::REG_COPY_W:  copy_w_r = val[12:0];
      yuvlc_pkg::REG_COPY_R:  copy_r_r = val[12:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic read_check(input logic [2:0] idx);
    logic [31:0] want;
    case (idx)
      yuvlc_pkg::REG_SRC_FMT: want = 32'(src_fmt_r);
      yuvlc_pkg::REG_TGT_FMT: want = 32'(tgt_fmt_r);
      yuvlc_pkg::REG_FRAME_W: want = 32'(frame_w_r);
      yuvlc_pkg::REG_FRAME_H: want = 32'(frame_h_r);
      yuvlc_pkg::REG_COPY_W:  want = 32'(copy_w_r);
      default:                want = 32'(copy_r_r);
    endcase
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    reg_reads++;
    if (prdata !== want) report_mismatch("register readback", prdata, want);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_writes.size() == 0) begin
          report_mismatch("write with nothing expected", 32'(out_byte_offset), 32'd0);
        end else begin
          head_write = pending_writes.pop_front();
          writes_checked++;
          if (out_byte_offset !== head_write.offset)
            report_mismatch("byte_offset", 32'(out_byte_offset),
                            32'(head_write.offset));
          if (out_byte_value !== head_write.value)
            report_mismatch("byte_value", 32'(out_byte_value), 32'(head_write.value));
          if (out_last_of_item !== head_write.last)
            report_mismatch("last_of_item", 32'(out_last_of_item),
                            32'(head_write.last));
          if (out_frame_done !== head_write.done)
            report_mismatch("frame_done", 32'(out_frame_done), 32'(head_write.done));
        end
      end
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: pop <= 1'b1;
        1: pop <= 1'($urandom_range(0, 1));
        2: pop <= ($urandom_range(0, 7) == 0);
        default: pop <= ((cycle_cnt % 16) >= 4);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no transaction for %0d cycles", QUIET_LIMIT);
      $display("tb_yuv420_layout_converter_core failed");
      $finish;
    end
  end

  initial begin
    int             k, start, stop_after;
    int unsigned    wide_stop;
    logic [12:0]    raw_w, raw_h;
    stim_row_t      r;
    logic [1:0]     n;
    yuvlc_pkg::wr_t wa, wb;

    src_fmt_r = yuvlc_pkg::RST_SRC_FMT;
    tgt_fmt_r = yuvlc_pkg::RST_TGT_FMT;
    frame_w_r = yuvlc_pkg::RST_FRAME_W;
    frame_h_r = yuvlc_pkg::RST_FRAME_H;
    copy_w_r = yuvlc_pkg::RST_COPY_W;
    copy_r_r = yuvlc_pkg::RST_COPY_R;
    clear_frame();

    dir_rows.push_back(typed_row(KIND_LUMA, 8'hff, 8'h00, 2'd2,
                                 25'd0, 8'hff, 25'd1, 8'h00, 1'b0));
    dir_rows.push_back(typed_row(KIND_CHROMA, 8'h12, 8'h34, 2'd0,
                                 25'd0, 8'h00, 25'd0, 8'h00, 1'b0));
    dir_rows.push_back(item_row(KIND_LUMA, 8'h00, 8'hff));
    dir_rows.push_back(reg_row(REG_BAD, 32'hffff_ffff));
    dir_rows.push_back(reg_row(yuvlc_pkg::REG_FRAME_W, 32'd5));
    dir_rows.push_back(reg_row(yuvlc_pkg::REG_FRAME_H, 32'd1));
    dir_rows.push_back(reg_row(yuvlc_pkg::REG_COPY_W, 32'd8191));
    dir_rows.push_back(reg_row(yuvlc_pkg::REG_COPY_R, 32'd0));
    dir_rows.push_back(item_row(KIND_LUMA, 8'h55, 8'haa));
    dir_rows.push_back(item_row(KIND_LUMA, 8'haa, 8'h55));
    dir_rows.push_back(item_row(KIND_LUMA, 8'h01, 8'h80));
    dir_rows.push_back(typed_row(KIND_LUMA, 8'h7e, 8'he7, 2'd0,
                                 25'd0, 8'h00, 25'd0, 8'h00, 1'b0));
    dir_rows.push_back(item_row(KIND_CHROMA, 8'h80, 8'h40));
    dir_rows.push_back(item_row(KIND_CHROMA, 8'h7f, 8'hfe));
    dir_rows.push_back(reg_row(yuvlc_pkg::REG_SRC_FMT, 32'(SRC_I420)));
    dir_rows.push_back(reg_row(yuvlc_pkg::REG_TGT_FMT, 32'(TGT_CODE3)));
    dir_rows.push_back(reg_row(yuvlc_pkg::REG_FRAME_W, 32'd8191));
    dir_rows.push_back(reg_row(yuvlc_pkg::REG_FRAME_H, 32'd8191));
    dir_rows.push_back(reg_row(yuvlc_pkg::REG_COPY_W, 32'd2));
    dir_rows.push_back(reg_row(yuvlc_pkg::REG_COPY_R, 32'd2));
    dir_rows.push_back(typed_row(KIND_LUMA, 8'h00, 8'hff, 2'd2,
                                 25'd0, 8'h00, 25'd1, 8'hff, 1'b0));
    dir_rows.push_back(typed_row(KIND_LUMA, 8'hff, 8'h00, 2'd2,
                                 25'd4096, 8'hff, 25'd4097, 8'h00, 1'b0));
    dir_rows.push_back(typed_row(KIND_CHROMA, 8'ha5, 8'h5a, 2'd2,
                                 25'd16777216, 8'ha5, 25'd20971520, 8'h5a, 1'b1));
    dir_rows.push_back(reg_row(yuvlc_pkg::REG_SRC_FMT, 32'(SRC_NV21)));
    dir_rows.push_back(reg_row(yuvlc_pkg::REG_TGT_FMT, 32'(TGT_NV21)));
    dir_rows.push_back(reg_row(yuvlc_pkg::REG_FRAME_W, 32'd2));
    dir_rows.push_back(reg_row(yuvlc_pkg::REG_FRAME_H, 32'd3));
    dir_rows.push_back(reg_row(yuvlc_pkg::REG_COPY_W, 32'd3));
    dir_rows.push_back(reg_row(yuvlc_pkg::REG_COPY_R, 32'd2));
    dir_rows.push_back(item_row(KIND_LUMA, 8'h80, 8'h7f));
    dir_rows.push_back(item_row(KIND_LUMA, 8'h01, 8'hfe));
    dir_rows.push_back(typed_row(KIND_CHROMA, 8'h3c, 8'hc3, 2'd2,
                                 25'd4, 8'h3c, 25'd5, 8'hc3, 1'b1));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      if (r.what == ROW_REG) begin
        wait_idle();
        write_reg(r.idx, r.val);
      end else begin
        send_item(r.kind, r.a, r.b, n, wa, wb);
        if (r.typed) begin
          n = r.n;
          wa = '{r.off0, r.v0, 1'b0, 1'b0};
          wb = '{r.off1, r.v1, 1'b1, r.done};
        end
        queue_writes(n, wa, wb);
      end
    end

    // wide row: run the column counter high, then shrink the copy width mid-frame
    wait_idle();
    write_reg(yuvlc_pkg::REG_SRC_FMT, $urandom_range(0, 1));
    write_reg(yuvlc_pkg::REG_TGT_FMT, $urandom_range(0, 3));
    write_reg(yuvlc_pkg::REG_FRAME_W, 32'd4096);
    write_reg(yuvlc_pkg::REG_FRAME_H, 32'd4096);
    write_reg(yuvlc_pkg::REG_COPY_W, 32'd4096);
    write_reg(yuvlc_pkg::REG_COPY_R, 32'd2);
    cfg_settings++;
    wide_stop = $urandom_range(2050, 2200);
    while (col_cnt < wide_stop) send_random_item();
    wait_idle();
    write_reg(yuvlc_pkg::REG_COPY_W, $urandom_range(0, 8));
    start = frames_done;
    while (frames_done == start) send_random_item();

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      wait_idle();
      raw_w = pick_frame_dim();
      raw_h = pick_frame_dim();
      write_reg(yuvlc_pkg::REG_SRC_FMT, $urandom_range(0, 1));
      write_reg(yuvlc_pkg::REG_TGT_FMT, $urandom_range(0, 3));
      write_reg(yuvlc_pkg::REG_FRAME_W, 32'(raw_w));
      write_reg(yuvlc_pkg::REG_FRAME_H, 32'(raw_h));
      write_reg(yuvlc_pkg::REG_COPY_W, 32'(pick_copy_dim(raw_w)));
      write_reg(yuvlc_pkg::REG_COPY_R, 32'(pick_copy_dim(raw_h)));
      cfg_settings++;
      for (k = 0; k < 6; k++) read_check(3'(k));
      if ($urandom_range(0, 5) == 0) begin
        stop_after = random_items + $urandom_range(1, 40);
        while (random_items < stop_after) send_random_item();
      end else begin
        start = frames_done;
        while (frames_done == start) send_random_item();
      end
    end

    wait_idle();
    $display("%0d items sent (%0d dropped as wrong kind), %0d writes checked, %0d frames",
             items_taken, items_dropped, writes_checked, frames_done);
    $display("%0d random register settings, %0d register reads compared",
             cfg_settings, reg_reads);
    if (err_count == 0) begin
      $display("tb_yuv420_layout_converter_core passed");
    end else begin
      $display("tb_yuv420_layout_converter_core failed");
    end
    $finish;
  end

endmodule
